>>> src/lwpf_pkg.sv
// ----------------------------------------------------------------------------
// lwpf_pkg
// Types and constants for the LCD window and pixel formatter.
// ----------------------------------------------------------------------------
package lwpf_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_WORD   = 2'd1,
    KIND_RGB24  = 2'd2,
    KIND_OFFROW = 2'd3
  } kind_t;

  localparam logic [1:0] ADDR_CONTROLLER_KIND = 2'd0;

  localparam logic REQ_WINDOW = 1'b0;
  localparam logic REQ_PIXEL  = 1'b1;

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  localparam logic [15:0] ROW_OFFSET = 16'd35;

  localparam logic [3:0] WINDOW_XFERS = 4'd11;
  localparam logic [3:0] RGB24_XFERS  = 4'd3;
  localparam logic [3:0] RGB565_XFERS = 4'd2;

  typedef struct packed {
    logic        is_pixel;
    logic        wide;
    logic        rgb24;
    logic [15:0] x;
    logic [15:0] xe;
    logic [15:0] y;
    logic [15:0] ye;
    logic [15:0] color;
  } req_t;

  typedef struct packed {
    logic [7:0] value;
    logic       is_command;
    logic       as_word;
    logic       last;
  } xfer_t;

endpackage

>>> src/lcd_window_and_pixel_formatter_core.sv
// ----------------------------------------------------------------------------
// lcd_window_and_pixel_formatter_core
// Turns window and pixel requests into command/data transfers for an SPI
// display controller.
// ----------------------------------------------------------------------------
//  channel   | handshake         | payload
//  request   | start / busy      | req_type, win_x, win_y, win_w, win_h, pixel_color
//  transfer  | strobe            | out_value, out_is_command, out_as_word, out_last
//  config    | APB psel/penable  | controller_kind at address 0
//
// A window request makes 11 transfers, a pixel request 2 (3 on the 24-bit colour
// panel): one transfer a cycle from the sequencer counter. The first transfer shows
// once the sequencer holds the request and the output register has taken it. busy
// drops while the last transfer of a request is formed, so requests follow with no
// gap. The receiver cannot stall. rst clears the sequencer, the strobe and controller_kind.
// ----------------------------------------------------------------------------
module lcd_window_and_pixel_formatter_core
  import lwpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [15:0] win_x,
  input  logic [15:0] win_y,
  input  logic [15:0] win_w,
  input  logic [15:0] win_h,
  input  logic [15:0] pixel_color,
  output logic        strobe,
  output logic [7:0]  out_value,
  output logic        out_is_command,
  output logic        out_as_word,
  output logic        out_last
);

  kind_t      controller_kind;
  req_t       req;
  req_t       req_next;
  logic       active;
  logic [3:0] idx;
  xfer_t      xfer;
  xfer_t      result;
  logic       accept;
  logic [15:0] y_adj;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CONTROLLER_KIND) ? {30'd0, controller_kind} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      controller_kind <= KIND_BYTE;
    end else if (psel && penable && pwrite) begin
      controller_kind <= kind_t'(pwdata[1:0]);
    end
  end

  assign busy   = active && !xfer.last;
  assign accept = start && !busy;

  always_comb begin
    y_adj             = (controller_kind == KIND_OFFROW) ? win_y + ROW_OFFSET : win_y;
    req_next.is_pixel = (req_type == REQ_PIXEL);
    req_next.wide     = (controller_kind == KIND_WORD);
    req_next.rgb24    = (controller_kind == KIND_RGB24);
    req_next.x        = win_x;
    req_next.xe       = win_x + win_w - 16'd1;
    req_next.y        = y_adj;
    req_next.ye       = y_adj + win_h - 16'd1;
    req_next.color    = pixel_color;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= req_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= 4'd0;
    end else if (accept) begin
      active <= 1'b1;
      idx    <= 4'd0;
    end else if (active && xfer.last) begin
      active <= 1'b0;
    end else if (active) begin
      idx <= idx + 4'd1;
    end
  end

  lwpf_xfer_sel u_sel (
    .req  (req),
    .idx  (idx),
    .xfer (xfer)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= active;
    end
  end

  always_ff @(posedge clk) begin
    result <= xfer;
  end

  assign out_value      = result.value;
  assign out_is_command = result.is_command;
  assign out_as_word    = result.as_word;
  assign out_last       = result.last;

`ifndef NO_ASSERTIONS
  a_busy_emits: assert property (@(posedge clk) disable iff (rst)
    busy |=> strobe)
    else $error("busy without a transfer following");

  a_accept_emits: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 strobe)
    else $error("accepted request gave no transfer");

  a_cmd_codes: assert property (@(posedge clk) disable iff (rst)
    (strobe && out_is_command) |->
      (out_value == CMD_COLUMN_SET || out_value == CMD_ROW_SET ||
       out_value == CMD_MEMORY_WRITE))
    else $error("command transfer with unknown code");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && !out_last) |=> strobe)
    else $error("transfer run ended without last");
`endif

endmodule

>>> src/lwpf_xfer_sel.sv
// ----------------------------------------------------------------------------
// lwpf_xfer_sel
// Picks the transfer at a given position of a held request.
// ----------------------------------------------------------------------------
module lwpf_xfer_sel
  import lwpf_pkg::*;
(
  input  req_t       req,
  input  logic [3:0] idx,
  output xfer_t      xfer
);

  logic [3:0] count;
  logic [7:0] win_value;
  logic       win_cmd;
  logic [7:0] pix_value;

  always_comb begin
    if (!req.is_pixel) begin
      count = WINDOW_XFERS;
    end else if (req.rgb24) begin
      count = RGB24_XFERS;
    end else begin
      count = RGB565_XFERS;
    end
  end

  always_comb begin
    win_cmd = 1'b0;
    case (idx)
      4'd0: begin
        win_value = CMD_COLUMN_SET;
        win_cmd   = 1'b1;
      end
      4'd1: win_value = req.x[15:8];
      4'd2: win_value = req.x[7:0];
      4'd3: win_value = req.xe[15:8];
      4'd4: win_value = req.xe[7:0];
      4'd5: begin
        win_value = CMD_ROW_SET;
        win_cmd   = 1'b1;
      end
      4'd6: win_value = req.y[15:8];
      4'd7: win_value = req.y[7:0];
      4'd8: win_value = req.ye[15:8];
      4'd9: win_value = req.ye[7:0];
      4'd10: begin
        win_value = CMD_MEMORY_WRITE;
        win_cmd   = 1'b1;
      end
      default: win_value = 8'h00;
    endcase
  end

  always_comb begin
    if (req.rgb24) begin
      case (idx)
        4'd0:    pix_value = {req.color[15:11], 3'b000};
        4'd1:    pix_value = {req.color[10:5], 2'b00};
        default: pix_value = {req.color[4:0], 3'b000};
      endcase
    end else begin
      case (idx)
        4'd0:    pix_value = req.color[15:8];
        default: pix_value = req.color[7:0];
      endcase
    end
  end

  always_comb begin
    xfer.value      = req.is_pixel ? pix_value : win_value;
    xfer.is_command = !req.is_pixel && win_cmd;
    xfer.as_word    = !req.is_pixel && req.wide;
    xfer.last       = (idx == count - 4'd1);
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lcd_window_and_pixel_formatter_core. Requests go in
// through start/busy in bursts with random gaps, and each one is expanded into
// its command/data transfers under the controller kind that is set at the
// time. Every strobed transfer is checked field by field against the oldest
// transfer still due. The run covers each controller kind, with the kind
// changed over APB only while the block is drained.
// ----------------------------------------------------------------------------
module testbench
  import lwpf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_PHASES = 8;
  localparam int RANDOM_PER_PHASE = 50;

  typedef struct packed {
    logic        req_type;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] color;
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type = 1'b0;
  logic [15:0] win_x = '0;
  logic [15:0] win_y = '0;
  logic [15:0] win_w = '0;
  logic [15:0] win_h = '0;
  logic [15:0] pixel_color = '0;
  logic        strobe;
  logic [7:0]  out_value;
  logic        out_is_command;
  logic        out_as_word;
  logic        out_last;

  request_t req_queue[$];
  xfer_t    due_xfers[$];
  kind_t    panel_kind = KIND_BYTE;
  int       n_errors = 0;

  lcd_window_and_pixel_formatter_core u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .req_type(req_type), .win_x(win_x), .win_y(win_y), .win_w(win_w),
    .win_h(win_h), .pixel_color(pixel_color),
    .strobe(strobe), .out_value(out_value), .out_is_command(out_is_command),
    .out_as_word(out_as_word), .out_last(out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void add_xfer(logic [7:0] value, logic is_cmd, logic word, logic last);
    xfer_t t;
    t.value = value;
    t.is_command = is_cmd;
    t.as_word = word;
    t.last = last;
    due_xfers.push_back(t);
  endfunction

  function automatic void format_request(request_t r);
    logic [15:0] row;
    logic [15:0] col_end;
    logic [15:0] row_end;
    logic        wd;
    wd = (panel_kind == KIND_WORD);
    row = (panel_kind == KIND_OFFROW) ? r.y + ROW_OFFSET : r.y;
    col_end = r.x + r.w - 16'd1;
    row_end = row + r.h - 16'd1;
    if (r.req_type == REQ_WINDOW) begin
      add_xfer(CMD_COLUMN_SET, 1'b1, wd, 1'b0);
      add_xfer(r.x[15:8], 1'b0, wd, 1'b0);
      add_xfer(r.x[7:0], 1'b0, wd, 1'b0);
      add_xfer(col_end[15:8], 1'b0, wd, 1'b0);
      add_xfer(col_end[7:0], 1'b0, wd, 1'b0);
      add_xfer(CMD_ROW_SET, 1'b1, wd, 1'b0);
      add_xfer(row[15:8], 1'b0, wd, 1'b0);
      add_xfer(row[7:0], 1'b0, wd, 1'b0);
      add_xfer(row_end[15:8], 1'b0, wd, 1'b0);
      add_xfer(row_end[7:0], 1'b0, wd, 1'b0);
      add_xfer(CMD_MEMORY_WRITE, 1'b1, wd, 1'b1);
    end else if (panel_kind == KIND_RGB24) begin
      add_xfer({r.color[15:11], 3'b000}, 1'b0, 1'b0, 1'b0);
      add_xfer({r.color[10:5], 2'b00}, 1'b0, 1'b0, 1'b0);
      add_xfer({r.color[4:0], 3'b000}, 1'b0, 1'b0, 1'b1);
    end else begin
      add_xfer(r.color[15:8], 1'b0, 1'b0, 1'b0);
      add_xfer(r.color[7:0], 1'b0, 1'b0, 1'b1);
    end
  endfunction

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.req_type = 1'($urandom_range(0, 1));
    r.x = pick_field();
    r.y = pick_field();
    r.w = pick_field();
    r.h = pick_field();
    r.color = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  function automatic void queue_request(logic kind, logic [15:0] x, logic [15:0] y,
                                        logic [15:0] w, logic [15:0] h,
                                        logic [15:0] color);
    req_queue.push_back('{kind, x, y, w, h, color});
  endfunction

  function automatic void queue_directed();
    queue_request(REQ_WINDOW, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    queue_request(REQ_WINDOW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    queue_request(REQ_WINDOW, 16'h1234, 16'hFFE0, 16'h0001, 16'h0020, 16'h5A5A);
    queue_request(REQ_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_request(REQ_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_request(REQ_PIXEL, 16'hA5C3, 16'h5A3C, 16'hFFFF, 16'h0000, 16'hA5C3);
  endfunction

  task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    panel_kind = kind_t'(data[1:0]);
  endtask

  task automatic drain();
    @(negedge clk);
    while (req_queue.size() != 0 || start || due_xfers.size() != 0) @(negedge clk);
  endtask

  // sender: bursts of requests separated by random gaps
  always @(posedge clk) begin : drive
    int       burst_left;
    int       gap_left;
    logic     go;
    request_t r;
    if (rst) begin
      start <= 1'b0;
      burst_left = $urandom_range(1, 16);
      gap_left = 0;
    end else if (!(start && busy)) begin
      go = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (req_queue.size() != 0) begin
        r = req_queue.pop_front();
        go = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
      if (!go) begin
        r = random_request();
      end
      start <= go;
      req_type <= r.req_type;
      win_x <= r.x;
      win_y <= r.y;
      win_w <= r.w;
      win_h <= r.h;
      pixel_color <= r.color;
    end
  end

  // check strobed transfers, then expand the request taken at this edge
  always @(posedge clk) begin : check
    xfer_t got;
    xfer_t want;
    if (!rst) begin
      got = '{out_value, out_is_command, out_as_word, out_last};
      if (strobe) begin
        if (due_xfers.size() == 0) begin
          if (n_errors < 10) begin
            $display("%0t: unexpected transfer value=%h cmd=%b word=%b last=%b",
                     $realtime, got.value, got.is_command, got.as_word, got.last);
          end
          n_errors++;
        end else begin
          want = due_xfers.pop_front();
          if (got.value !== want.value || got.is_command !== want.is_command ||
              got.as_word !== want.as_word || got.last !== want.last) begin
            if (n_errors < 10) begin
              $display("%0t: transfer mismatch exp value=%h cmd=%b word=%b last=%b",
                       $realtime, want.value, want.is_command, want.as_word, want.last);
              $display("%0t:                   got value=%h cmd=%b word=%b last=%b",
                       $realtime, got.value, got.is_command, got.as_word, got.last);
            end
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        format_request('{req_type, win_x, win_y, win_w, win_h, pixel_color});
      end
    end
  end

  initial begin
    kind_t kind_plan[N_PHASES];
    kind_plan = '{KIND_BYTE, KIND_OFFROW, KIND_WORD, KIND_RGB24, KIND_BYTE,
                  kind_t'($urandom_range(0, 3)), kind_t'($urandom_range(0, 3)),
                  kind_t'($urandom_range(0, 3))};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        repeat (4) @(posedge clk);
        apb_write(ADDR_CONTROLLER_KIND, {30'd0, kind_plan[ph]});
      end
      @(negedge clk);
      if (ph < 4) begin
        queue_directed();
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        req_queue.push_back(random_request());
      end
    end
    drain();
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
